[rtl/core/sorted_key_set_defines.svh]
// Assertion macros for the sorted key set checker.
`ifndef SORTED_KEY_SET_DEFINES_SVH
`define SORTED_KEY_SET_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SKS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted key set assertion failed");

// Next-cycle implication, disabled while in reset.
`define SKS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted key set assertion failed");

`endif

[rtl/core/sks_pkg.sv]
// Types and constants for the sorted key set.
package sks_pkg;

   localparam int KEY_FIELD_BITS = 16;
   localparam int POS_FIELD_BITS = 5;
   localparam int CNT_FIELD_BITS = 6;
   localparam int REQ_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } sks_op_type;

   typedef enum logic [1:0] {
      STAT_DONE = 2'd0,
      STAT_DUP  = 2'd1,
      STAT_MISS = 2'd2,
      STAT_FULL = 2'd3
   } sks_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_PUT_KEY,
      S_EMIT
   } sks_state_type;

endpackage

[rtl/core/sks_mem.sv]
// Key store: one write port, one read port with registered read data.
module sks_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/sorted_key_set.sv]
// A request is accepted in S_IDLE. S_SCAN reads one key at a time (at least one) up to the first key
// not below the request key; an insert that must make room then shifts keys up in S_SHIFT_UP and
// writes the key in S_PUT_KEY, and a delete shifts any later keys down in S_SHIFT_DN. A clear goes
// straight to S_EMIT, which loads the result. One request at a time: the next is accepted once
// the result is loaded, later while an unaccepted result still holds the output register.
// Reset (synchronous, active high) empties the set; the key store itself is not cleared.
module sorted_key_set
   import sks_pkg::*;
#(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // key[15:0]
   input  logic [1:0]               req_tuser,  // operation[1:0]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // found[0], position[5:1], entry_count[11:6]
   output logic [1:0]               rsp_tuser   // status[1:0]
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   sks_state_type            state_ff, state_in;
   sks_op_type               op_ff, op_in;
   logic [KEY_BITS-1:0]      key_ff, key_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            pos_ff, pos_in;
   logic [CW-1:0]            j_ff, j_in;
   sks_status_type           status_ff, status_in;
   logic                     found_ff, found_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_user_ff, rsp_user_in;

   logic                     rd_en, wr_en;
   logic [AW-1:0]            rd_addr, wr_addr;
   logic [KEY_BITS-1:0]      wr_data, rd_data;

   logic [KEY_BITS+15:0]     key_pad;
   logic [KEY_BITS-1:0]      key_ext;
   logic [CW:0]              pos_p1, j_p1, j_p2, r_idx_p1;
   logic [CW-1:0]            count_m1, j_m1, j_m2, r_idx;
   logic                     entry_ok, entry_lt, r_hit;

   assign key_pad = {{KEY_BITS{1'b0}}, req_tdata[KEY_FIELD_BITS-1:0]};
   assign key_ext = key_pad[KEY_BITS-1:0];

   assign pos_p1   = {1'b0, pos_ff} + 1'b1;
   assign j_p1     = {1'b0, j_ff} + 1'b1;
   assign j_p2     = {1'b0, j_ff} + 2'd2;
   assign count_m1 = count_ff - 1'b1;
   assign j_m1     = j_ff - 1'b1;
   assign j_m2     = j_ff - 2'd2;
   assign entry_ok = pos_ff < count_ff;
   assign entry_lt = rd_data < key_ff;
   assign r_idx    = (entry_ok && entry_lt) ? pos_p1[CW-1:0] : pos_ff;
   assign r_hit    = entry_ok && (rd_data == key_ff);
   assign r_idx_p1 = {1'b0, r_idx} + 1'b1;

   sks_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_BITS)
   ) u_sks_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      j_ff        <= j_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = sks_op_type'(req_tuser);
               key_in    = key_ext;
               pos_in    = '0;
               found_in  = 1'b0;
               status_in = STAT_DONE;
               if (sks_op_type'(req_tuser) == OP_CLEAR) begin
                  count_in = '0;
                  state_in = S_EMIT;
               end else begin
                  rd_en    = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (entry_ok && entry_lt && (pos_p1 < {1'b0, count_ff})) begin
               rd_en   = 1'b1;
               rd_addr = pos_p1[AW-1:0];
               pos_in  = pos_p1[CW-1:0];
            end else begin
               pos_in   = r_idx;
               state_in = S_EMIT;
               case (op_ff)
                  OP_INSERT: begin
                     if (r_hit) begin
                        status_in = STAT_DUP;
                        found_in  = 1'b1;
                     end else if (count_ff == CAP_CNT) begin
                        status_in = STAT_FULL;
                        pos_in    = '0;
                     end else if (r_idx == count_ff) begin
                        wr_en    = 1'b1;
                        wr_addr  = r_idx[AW-1:0];
                        wr_data  = key_ff;
                        count_in = count_ff + 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = count_m1[AW-1:0];
                        j_in     = count_ff;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  OP_DELETE: begin
                     if (r_hit) begin
                        found_in = 1'b1;
                        if (r_idx_p1 < {1'b0, count_ff}) begin
                           rd_en    = 1'b1;
                           rd_addr  = r_idx_p1[AW-1:0];
                           j_in     = r_idx;
                           state_in = S_SHIFT_DN;
                        end else begin
                           count_in = count_m1;
                        end
                     end else begin
                        status_in = STAT_MISS;
                        pos_in    = '0;
                     end
                  end
                  default: begin
                     if (r_hit) begin
                        found_in = 1'b1;
                     end else begin
                        status_in = STAT_MISS;
                        pos_in    = '0;
                     end
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = rd_data;
            if (j_m1 > pos_ff) begin
               rd_en   = 1'b1;
               rd_addr = j_m2[AW-1:0];
               j_in    = j_m1;
            end else begin
               state_in = S_PUT_KEY;
            end
         end
         S_PUT_KEY: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[AW-1:0];
            wr_data  = key_ff;
            count_in = count_ff + 1'b1;
            state_in = S_EMIT;
         end
         S_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = rd_data;
            if (j_p2 < {1'b0, count_ff}) begin
               rd_en   = 1'b1;
               rd_addr = j_p2[AW-1:0];
               j_in    = j_p1[CW-1:0];
            end else begin
               count_in = count_m1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {4'b0000, CNT_FIELD_BITS'(count_ff),
                               POS_FIELD_BITS'(pos_ff), found_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/core/sks_checker.sv]
// Port-level checker for the sorted key set, bound to the top level.
`include "sorted_key_set_defines.svh"

module sks_checker
   import sks_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic [1:0]               req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [1:0]               rsp_tuser
);

   `SKS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `SKS_ASSERT_NEXT(a_one_request, req_tvalid && req_tready, !req_tready)
   `SKS_ASSERT_NOW(a_miss_clean, rsp_tvalid && (rsp_tuser == STAT_MISS || rsp_tuser == STAT_FULL), rsp_tdata[5:0] == 6'd0)
   `SKS_ASSERT_NOW(a_dup_found, rsp_tvalid && rsp_tuser == STAT_DUP, rsp_tdata[0])
   `SKS_ASSERT_NOW(a_full_count, rsp_tvalid && rsp_tuser == STAT_FULL, rsp_tdata[11:6] == 6'(CAPACITY))

endmodule

bind sorted_key_set sks_checker #(.CAPACITY(CAPACITY)) u_sks_checker (.*);

[test/tb_top.sv]
// Self-checking testbench for sorted_key_set: a table of directed requests, then random traffic.
module tb_top;
   import sks_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_CAPACITY = 32;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 80;
   localparam int RANDOM_ITEMS = 600;
   localparam int NUM_ROWS     = 20;

   typedef struct packed {
      sks_status_type status;
      logic           found;
      logic [4:0]     position;
      logic [5:0]     count;
   } set_result_type;

   typedef struct packed {
      sks_op_type     op;
      logic [15:0]    key;
      logic           typed;
      sks_status_type status;
      logic           found;
      logic [4:0]     position;
      logic [5:0]     count;
   } dir_row_type;

   typedef enum int {
      MODE_GROW,
      MODE_SHRINK,
      MODE_MIX
   } traffic_mode_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [1:0]               req_tuser  = OP_INSERT;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]               rsp_tuser;

   logic [15:0]    set_keys [SET_CAPACITY];
   int             set_size = 0;
   int             peak_size = 0;
   set_result_type pending_results [$];
   bit             idle_on = 1'b1;
   int             error_count = 0;
   int             quiet_cycles = 0;
   int             op_count [4] = '{0, 0, 0, 0};
   int             status_count [4] = '{0, 0, 0, 0};

   // operation, key, typed-in, status, found, position, entry count
   dir_row_type directed_rows [NUM_ROWS] = '{
      '{OP_LOOKUP, 16'h0000, 1'b1, STAT_MISS, 1'b0, 5'd0, 6'd0},
      '{OP_DELETE, 16'hFFFF, 1'b1, STAT_MISS, 1'b0, 5'd0, 6'd0},
      '{OP_INSERT, 16'h8000, 1'b1, STAT_DONE, 1'b0, 5'd0, 6'd1},
      '{OP_INSERT, 16'h0000, 1'b1, STAT_DONE, 1'b0, 5'd0, 6'd2},
      '{OP_INSERT, 16'hFFFF, 1'b1, STAT_DONE, 1'b0, 5'd2, 6'd3},
      '{OP_INSERT, 16'h8000, 1'b1, STAT_DUP,  1'b1, 5'd1, 6'd3},
      '{OP_LOOKUP, 16'h0000, 1'b1, STAT_DONE, 1'b1, 5'd0, 6'd3},
      '{OP_LOOKUP, 16'hFFFF, 1'b1, STAT_DONE, 1'b1, 5'd2, 6'd3},
      '{OP_LOOKUP, 16'h7FFF, 1'b1, STAT_MISS, 1'b0, 5'd0, 6'd3},
      '{OP_INSERT, 16'h7FFF, 1'b0, STAT_DONE, 1'b0, 5'd0, 6'd0},
      '{OP_INSERT, 16'h8001, 1'b0, STAT_DONE, 1'b0, 5'd0, 6'd0},
      '{OP_DELETE, 16'h0000, 1'b1, STAT_DONE, 1'b1, 5'd0, 6'd4},
      '{OP_DELETE, 16'hFFFF, 1'b1, STAT_DONE, 1'b1, 5'd3, 6'd3},
      '{OP_DELETE, 16'hFFFF, 1'b1, STAT_MISS, 1'b0, 5'd0, 6'd3},
      '{OP_LOOKUP, 16'h8001, 1'b0, STAT_DONE, 1'b0, 5'd0, 6'd0},
      '{OP_CLEAR,  16'h1234, 1'b1, STAT_DONE, 1'b0, 5'd0, 6'd0},
      '{OP_LOOKUP, 16'h8000, 1'b1, STAT_MISS, 1'b0, 5'd0, 6'd0},
      '{OP_INSERT, 16'hAAAA, 1'b1, STAT_DONE, 1'b0, 5'd0, 6'd1},
      '{OP_INSERT, 16'h5555, 1'b1, STAT_DONE, 1'b0, 5'd0, 6'd2},
      '{OP_CLEAR,  16'hFFFF, 1'b1, STAT_DONE, 1'b0, 5'd0, 6'd0}
   };

   sorted_key_set #(
      .CAPACITY(SET_CAPACITY),
      .KEY_BITS(16)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40) begin
         $display("ERROR %0t ns: %s", $time, what);
      end
   endtask

   // Applies one request to the local copy of the set and returns its result.
   function automatic set_result_type apply_set_op(input sks_op_type op, input logic [15:0] key);
      set_result_type r;
      int             slot;
      bit             hit;
      r = '0;
      r.status = STAT_DONE;
      slot = 0;
      hit = 1'b0;
      if (op != OP_CLEAR) begin
         while (slot < set_size && set_keys[slot] < key) slot++;
         hit = (slot < set_size) && (set_keys[slot] == key);
      end
      case (op)
         OP_INSERT: begin
            if (hit) begin
               r.status = STAT_DUP;
               r.found = 1'b1;
               r.position = slot[4:0];
            end else if (set_size >= SET_CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               for (int j = set_size; j > slot; j--) set_keys[j] = set_keys[j-1];
               set_keys[slot] = key;
               set_size++;
               r.position = slot[4:0];
            end
         end
         OP_DELETE: begin
            if (hit) begin
               r.found = 1'b1;
               r.position = slot[4:0];
               for (int j = slot; j + 1 < set_size; j++) set_keys[j] = set_keys[j+1];
               set_size--;
            end else begin
               r.status = STAT_MISS;
            end
         end
         OP_LOOKUP: begin
            if (hit) begin
               r.found = 1'b1;
               r.position = slot[4:0];
            end else begin
               r.status = STAT_MISS;
            end
         end
         default: set_size = 0;
      endcase
      r.count = set_size[5:0];
      if (set_size > peak_size) peak_size = set_size;
      return r;
   endfunction

   // Mostly keys already held or their neighbors, so hits and ordering get exercised.
   function automatic logic [15:0] pick_key();
      int          r;
      logic [15:0] k;
      r = $urandom_range(99);
      if (set_size > 0 && r < 55) begin
         k = set_keys[$urandom_range(set_size - 1)];
      end else if (set_size > 0 && r < 70) begin
         k = set_keys[$urandom_range(set_size - 1)] + ($urandom_range(1) ? 16'h0001 : 16'hFFFF);
      end else if (r < 80) begin
         k = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      end else begin
         k = 16'($urandom());
      end
      return k;
   endfunction

   function automatic sks_op_type pick_op(input traffic_mode_type mode);
      int r;
      int ins_w;
      int del_w;
      r = $urandom_range(99);
      case (mode)
         MODE_GROW: begin
            ins_w = 60;
            del_w = 12;
         end
         MODE_SHRINK: begin
            ins_w = 15;
            del_w = 55;
         end
         default: begin
            ins_w = 35;
            del_w = 30;
         end
      endcase
      if (r == 99) return OP_CLEAR;
      if (r < ins_w) return OP_INSERT;
      if (r < ins_w + del_w) return OP_DELETE;
      return OP_LOOKUP;
   endfunction

   task automatic drive_request(input sks_op_type op, input logic [15:0] key);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= key;
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic push_expected(input sks_op_type op, input set_result_type r);
      pending_results.push_back(r);
      op_count[op]++;
      status_count[r.status]++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= !(idle_on && $urandom_range(99) < 30);
      end
   end

   always @(posedge clock) begin : rsp_check
      set_result_type want;
      sks_status_type got_status;
      logic           got_found;
      logic [4:0]     got_pos;
      logic [5:0]     got_count;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = sks_status_type'(rsp_tuser);
         got_found = rsp_tdata[0];
         got_pos = rsp_tdata[5:1];
         got_count = rsp_tdata[11:6];
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            if (got_status !== want.status || got_found !== want.found
                || got_pos !== want.position || got_count !== want.count
                || rsp_tdata[15:12] !== 4'd0) begin
               report_mismatch($sformatf(
                  "status %0d/%0d found %0d/%0d pos %0d/%0d count %0d/%0d pad %h (exp/got)",
                  want.status, got_status, want.found, got_found, want.position, got_pos,
                  want.count, got_count, rsp_tdata[15:12]));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("sorted_key_set: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      traffic_mode_type mode;
      sks_op_type       op;
      logic [15:0]      key;
      set_result_type   r;
      mode = MODE_GROW;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         drive_request(directed_rows[i].op, directed_rows[i].key);
         r = apply_set_op(directed_rows[i].op, directed_rows[i].key);
         if (directed_rows[i].typed) begin
            r.status = directed_rows[i].status;
            r.found = directed_rows[i].found;
            r.position = directed_rows[i].position;
            r.count = directed_rows[i].count;
         end
         push_expected(directed_rows[i].op, r);
      end
      wait_for_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            mode = (i == 0) ? MODE_GROW : traffic_mode_type'($urandom_range(2));
         end
         idle_on = !(i >= 250 && i < 400);
         if (i == 150 || i == 470) wait_for_results();
         op = pick_op(mode);
         key = pick_key();
         drive_request(op, key);
         push_expected(op, apply_set_op(op, key));
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("requests: %0d insert, %0d delete, %0d lookup, %0d clear; peak set size %0d",
               op_count[OP_INSERT], op_count[OP_DELETE], op_count[OP_LOOKUP],
               op_count[OP_CLEAR], peak_size);
      $display("results: %0d done, %0d duplicate, %0d not found, %0d full; %0d errors",
               status_count[STAT_DONE], status_count[STAT_DUP], status_count[STAT_MISS],
               status_count[STAT_FULL], error_count);
      if (error_count == 0) begin
         $display("sorted_key_set: match");
      end else begin
         $display("sorted_key_set: mismatch");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sks_pkg.sv
rtl/core/sks_mem.sv
rtl/core/sorted_key_set.sv
rtl/core/sks_checker.sv
test/tb_top.sv
